// File: design/kufa_pkg.sv
// Shared widths and types for the union-find spanning-tree accumulator.
package kufa_pkg;

   localparam int WEIGHT_W  = 32;
   localparam int NODE_W    = 10;
   localparam int TOTAL_W   = 48;
   localparam int IDX_EXT_W = 17;

   typedef struct packed {
      logic fire;
      logic joined;
      logic last;
   } resp_ctl_type;

endpackage

// File: design/kufa_parent_ram.sv
// Parent table memory: one write port, one registered read port.
module kufa_parent_ram #(
   parameter int NODES = 1024
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(NODES)-1:0]  wr_addr,
   input  logic [$clog2(NODES)-1:0]  wr_data,
   input  logic [$clog2(NODES)-1:0]  rd_addr,
   output logic [$clog2(NODES)-1:0]  rd_data
);
   localparam int AW = $clog2(NODES);

   logic [AW-1:0] parent_mem [NODES];
   logic [AW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         parent_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= parent_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/kufa_find_ctrl.sv
// Sequencer: table clear sweep, path-halving root search for both endpoints, link.
module kufa_find_ctrl #(
   parameter int NODES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [kufa_pkg::NODE_W-1:0]   req_node_a,
   input  logic [kufa_pkg::NODE_W-1:0]   req_node_b,
   input  logic                          req_last_edge,
   output logic                          wr_en,
   output logic [$clog2(NODES)-1:0]      wr_addr,
   output logic [$clog2(NODES)-1:0]      wr_data,
   output logic [$clog2(NODES)-1:0]      rd_addr,
   input  logic [$clog2(NODES)-1:0]      rd_data,
   output kufa_pkg::resp_ctl_type        ctl
);
   import kufa_pkg::*;

   localparam int AW = $clog2(NODES);
   localparam logic [IDX_EXT_W-1:0] NODES_EXT = IDX_EXT_W'(NODES);
   localparam logic [AW-1:0] LAST_IDX = AW'(NODES - 1);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_PARENT = 2'd2;
   localparam logic [1:0] S_GRAND  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] v_ff, v_in;
   logic [AW-1:0] ra_ff, ra_in;
   logic [AW-1:0] b_ff, b_in;
   logic          phase_ff, phase_in;
   logic          last_ff, last_in;

   logic [IDX_EXT_W-1:0] a_ext;
   logic [IDX_EXT_W-1:0] b_ext;
   logic                 in_range;

   assign a_ext    = IDX_EXT_W'(req_node_a);
   assign b_ext    = IDX_EXT_W'(req_node_b);
   assign in_range = (a_ext < NODES_EXT) && (b_ext < NODES_EXT);
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      v_in       = v_ff;
      ra_in      = ra_ff;
      b_in       = b_ff;
      phase_in   = phase_ff;
      last_in    = last_ff;
      wr_en      = 1'b0;
      wr_addr    = v_ff;
      wr_data    = rd_data;
      rd_addr    = v_ff;
      ctl.fire   = 1'b0;
      ctl.joined = 1'b0;
      ctl.last   = last_ff;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = cnt_ff;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = AW'(cnt_ff + 1'b1);
            end
         end
         S_IDLE: begin
            if (start) begin
               last_in = req_last_edge;
               if (in_range) begin
                  v_in     = a_ext[AW-1:0];
                  b_in     = b_ext[AW-1:0];
                  rd_addr  = a_ext[AW-1:0];
                  phase_in = 1'b0;
                  state_in = S_PARENT;
               end else begin
                  ctl.fire = 1'b1;
                  ctl.last = req_last_edge;
                  state_in = req_last_edge ? S_CLEAR : S_IDLE;
               end
            end
         end
         S_PARENT: begin
            if (rd_data == v_ff) begin
               if (!phase_ff) begin
                  ra_in    = v_ff;
                  v_in     = b_ff;
                  rd_addr  = b_ff;
                  phase_in = 1'b1;
               end else begin
                  wr_en      = (ra_ff != v_ff);
                  wr_addr    = ra_ff;
                  wr_data    = v_ff;
                  ctl.fire   = 1'b1;
                  ctl.joined = (ra_ff != v_ff);
                  state_in   = last_ff ? S_CLEAR : S_IDLE;
               end
            end else begin
               rd_addr  = rd_data;
               state_in = S_GRAND;
            end
         end
         S_GRAND: begin
            wr_en    = 1'b1;
            wr_addr  = v_ff;
            wr_data  = rd_data;
            v_in     = rd_data;
            rd_addr  = rd_data;
            state_in = S_PARENT;
         end
         default: begin
            state_in = S_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
      end
      v_ff  <= v_in;
      ra_ff <= ra_in;
      b_ff  <= b_in;
   end

endmodule

// File: design/kufa_accum.sv
// Saturating tree total and registered result beat.
module kufa_accum (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_fire,
   input  logic [kufa_pkg::WEIGHT_W-1:0]  req_edge_weight,
   input  kufa_pkg::resp_ctl_type         ctl,
   output logic                           rsp_valid,
   output logic                           rsp_joined,
   output logic [kufa_pkg::TOTAL_W-1:0]   rsp_tree_total,
   output logic                           rsp_last_result
);
   import kufa_pkg::*;

   logic [WEIGHT_W-1:0] weight_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic                rsp_valid_ff;
   logic                rsp_joined_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   logic                rsp_last_ff;

   logic [TOTAL_W:0]    sum;
   logic [TOTAL_W-1:0]  total_in;

   assign sum = {1'b0, total_ff} + {{(TOTAL_W - WEIGHT_W + 1){1'b0}}, weight_ff};

   always_comb begin
      total_in = total_ff;
      if (ctl.joined) begin
         total_in = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.fire;
         if (ctl.fire) begin
            total_ff <= ctl.last ? '0 : total_in;
         end
      end
      if (req_fire) begin
         weight_ff <= req_edge_weight;
      end
      if (ctl.fire) begin
         rsp_joined_ff <= ctl.joined;
         rsp_total_ff  <= total_in;
         rsp_last_ff   <= ctl.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_joined      = rsp_joined_ff;
   assign rsp_tree_total  = rsp_total_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

// File: design/kruskal_union_find_accumulate_top.sv
// Kruskal spanning-tree accumulator over a union-find parent table in one memory.
//
// Edges arrive sorted by weight; an edge is taken when start is high and busy is low,
// and its result appears on rsp_* for a single cycle marked by rsp_valid. The receiver
// cannot stall: sample every rsp_valid beat. Per edge the work is accept and report
// plus, for each endpoint, a root check and a parent read and grandparent write-back
// per path-halving step, all paced by the registered read port of the parent memory.
// An edge with an endpoint of NODES or more is reported unjoined in the cycle right
// after accept. After reset, and after every last edge, busy stays high while the
// table is swept back to identity.
module kruskal_union_find_accumulate_top #(
   parameter int NODES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [kufa_pkg::WEIGHT_W-1:0]  req_edge_weight,
   input  logic [kufa_pkg::NODE_W-1:0]    req_node_a,
   input  logic [kufa_pkg::NODE_W-1:0]    req_node_b,
   input  logic                           req_last_edge,
   output logic                           rsp_valid,
   output logic                           rsp_joined,
   output logic [kufa_pkg::TOTAL_W-1:0]   rsp_tree_total,
   output logic                           rsp_last_result
);
   import kufa_pkg::*;

   localparam int AW = $clog2(NODES);

   logic          req_fire;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] rd_data;
   resp_ctl_type  ctl;

   assign req_fire = start && !busy;

   kufa_parent_ram #(.NODES(NODES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kufa_find_ctrl #(.NODES(NODES)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_node_a    (req_node_a),
      .req_node_b    (req_node_b),
      .req_last_edge (req_last_edge),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .ctl           (ctl)
   );

   kufa_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .req_fire        (req_fire),
      .req_edge_weight (req_edge_weight),
      .ctl             (ctl),
      .rsp_valid       (rsp_valid),
      .rsp_joined      (rsp_joined),
      .rsp_tree_total  (rsp_tree_total),
      .rsp_last_result (rsp_last_result)
   );

   a_beat_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(req_fire)))
      else $error("result beat without an edge in flight");

   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> busy)
      else $error("parent table written while idle");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |-> busy)
      else $error("no clear sweep after last edge");

   a_no_accept_during_work: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |=> busy)
      else $error("clear sweep ended too early");

endmodule

// File: tb/tree_total_checker.sv
`timescale 1ns / 1ps
// Checker for the spanning-tree accumulator: predicts each edge's result and compares beats.
module tree_total_checker #(
   parameter int NODES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [kufa_pkg::WEIGHT_W-1:0]  req_edge_weight,
   input  logic [kufa_pkg::NODE_W-1:0]    req_node_a,
   input  logic [kufa_pkg::NODE_W-1:0]    req_node_b,
   input  logic                           req_last_edge,
   input  logic                           rsp_valid,
   input  logic                           rsp_joined,
   input  logic [kufa_pkg::TOTAL_W-1:0]   rsp_tree_total,
   input  logic                           rsp_last_result,
   output int                             fail_count,
   output int                             pending_count
);
   import kufa_pkg::*;

   localparam logic [TOTAL_W-1:0] TOTAL_CEILING = {TOTAL_W{1'b1}};

   typedef struct packed {
      logic               joined;
      logic [TOTAL_W-1:0] tree_total;
      logic               last;
   } edge_outcome_type;

   logic [IDX_EXT_W-1:0] parent_link [NODES];
   logic [TOTAL_W-1:0]   tree_sum;
   edge_outcome_type     expected_outcomes [$];
   int                   failures = 0;

   assign fail_count = failures;

   function automatic void clear_forest();
      for (int i = 0; i < NODES; i++)
         parent_link[i] = IDX_EXT_W'(i);
      tree_sum = '0;
   endfunction

   function automatic logic [IDX_EXT_W-1:0] find_root(input logic [IDX_EXT_W-1:0] node);
      logic [IDX_EXT_W-1:0] up;
      logic [IDX_EXT_W-1:0] grand;
      int                   steps;
      steps = 0;
      while (node < NODES && parent_link[node] != node && steps < NODES) begin
         up = parent_link[node];
         grand = (up < NODES) ? parent_link[up] : up;
         parent_link[node] = grand;
         node = grand;
         steps++;
      end
      return node;
   endfunction

   function automatic void predict_edge(input logic [WEIGHT_W-1:0] weight,
                                        input logic [NODE_W-1:0] node_a,
                                        input logic [NODE_W-1:0] node_b,
                                        input logic last);
      logic [IDX_EXT_W-1:0] root_a;
      logic [IDX_EXT_W-1:0] root_b;
      logic [TOTAL_W-1:0]   wide_weight;
      edge_outcome_type     outcome;
      wide_weight = TOTAL_W'(weight);
      outcome.joined = 1'b0;
      if (node_a < NODES && node_b < NODES) begin
         root_a = find_root(IDX_EXT_W'(node_a));
         root_b = find_root(IDX_EXT_W'(node_b));
         if (root_a != root_b) begin
            parent_link[root_a] = root_b;
            outcome.joined = 1'b1;
            if (tree_sum > TOTAL_CEILING - wide_weight)
               tree_sum = TOTAL_CEILING;
            else
               tree_sum = tree_sum + wide_weight;
         end
      end
      outcome.tree_total = tree_sum;
      outcome.last = last;
      expected_outcomes.insert(expected_outcomes.size(), outcome);
      if (last)
         clear_forest();
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      failures++;
   endtask

   always @(posedge clock) begin
      edge_outcome_type want;
      if (reset) begin
         clear_forest();
         expected_outcomes.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch($sformatf("result beat with none expected (joined %0b total %0d)",
                                         rsp_joined, rsp_tree_total));
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_joined !== want.joined)
                  report_mismatch($sformatf("joined got %b want %b", rsp_joined, want.joined));
               if (rsp_tree_total !== want.tree_total)
                  report_mismatch($sformatf("tree_total got %0d want %0d",
                                            rsp_tree_total, want.tree_total));
               if (rsp_last_result !== want.last)
                  report_mismatch($sformatf("last_result got %b want %b",
                                            rsp_last_result, want.last));
            end
         end
         if (start && !busy)
            predict_edge(req_edge_weight, req_node_a, req_node_b, req_last_edge);
      end
      pending_count <= expected_outcomes.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench top: feeds directed and random graphs to the spanning-tree accumulator.
module testbench;
   import kufa_pkg::*;

   localparam int NODE_COUNT = 1024;
   localparam int EDGE_ITEMS = 1800;
   localparam int CALM_TAIL  = 150;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [WEIGHT_W-1:0] req_edge_weight = '0;
   logic [NODE_W-1:0]   req_node_a = '0;
   logic [NODE_W-1:0]   req_node_b = '0;
   logic                req_last_edge = 1'b0;
   logic                rsp_valid;
   logic                rsp_joined;
   logic [TOTAL_W-1:0]  rsp_tree_total;
   logic                rsp_last_result;
   int                  fail_count;
   int                  pending_count;
   int                  edges_sent = 0;
   bit                  gaps_on = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   kruskal_union_find_accumulate_top #(
      .NODES(NODE_COUNT)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_edge_weight (req_edge_weight),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_last_edge   (req_last_edge),
      .rsp_valid       (rsp_valid),
      .rsp_joined      (rsp_joined),
      .rsp_tree_total  (rsp_tree_total),
      .rsp_last_result (rsp_last_result)
   );

   tree_total_checker #(
      .NODES(NODE_COUNT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_edge_weight (req_edge_weight),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_last_edge   (req_last_edge),
      .rsp_valid       (rsp_valid),
      .rsp_joined      (rsp_joined),
      .rsp_tree_total  (rsp_tree_total),
      .rsp_last_result (rsp_last_result),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   task automatic send_edge(input logic [WEIGHT_W-1:0] weight,
                            input logic [NODE_W-1:0] node_a,
                            input logic [NODE_W-1:0] node_b,
                            input logic last);
      if (gaps_on && edges_sent < EDGE_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      start <= 1'b1;
      req_edge_weight <= weight;
      req_node_a <= node_a;
      req_node_b <= node_b;
      req_last_edge <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      edges_sent++;
   endtask

   task automatic send_random_graph();
      int                  edge_total;
      int                  span;
      bit                  ascending;
      logic [NODE_W-1:0]   base;
      logic [WEIGHT_W-1:0] weight;
      logic [WEIGHT_W:0]   next_weight;
      edge_total = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      span = ($urandom_range(0, 7) == 0) ? NODE_COUNT : $urandom_range(2, 40);
      base = NODE_W'($urandom());
      ascending = ($urandom_range(0, 9) != 0);
      weight = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom();
      gaps_on = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < edge_total; i++) begin
         if (!ascending) begin
            weight = $urandom();
         end else if (i != 0) begin
            next_weight = {1'b0, weight}
                        + (WEIGHT_W + 1)'($urandom_range(0, 1 << $urandom_range(0, 24)));
            weight = next_weight[WEIGHT_W] ? {WEIGHT_W{1'b1}} : next_weight[WEIGHT_W-1:0];
         end
         send_edge(weight,
                   base + NODE_W'($urandom_range(0, span - 1)),
                   base + NODE_W'($urandom_range(0, span - 1)),
                   i == edge_total - 1);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // extremes of the node range, maximum weight, self loop, last edge
      send_edge(32'h0000_0000, 10'd0, 10'd1023, 1'b0);
      send_edge(32'hFFFF_FFFF, 10'd1023, 10'd0, 1'b0);
      send_edge(32'hFFFF_FFFF, 10'd5, 10'd5, 1'b0);
      send_edge(32'hFFFF_FFFF, 10'd512, 10'd511, 1'b0);
      send_edge(32'hFFFF_FFFF, 10'd1023, 10'd511, 1'b0);
      send_edge(32'h5555_5555, 10'd682, 10'd341, 1'b1);

      // long parent chain, then walk it from the far end
      gaps_on = 1'b1;
      for (int i = 0; i < 12; i++)
         send_edge(WEIGHT_W'(100 + i), NODE_W'(i), NODE_W'(i + 1), 1'b0);
      send_edge(32'd200, 10'd0, 10'd12, 1'b0);
      send_edge(32'd201, 10'd12, 10'd0, 1'b0);
      send_edge(32'd300, 10'd0, 10'd700, 1'b0);
      send_edge(32'd301, 10'd3, 10'd3, 1'b1);

      gaps_on = 1'b0;
      send_edge(32'hFFFF_FFFF, 10'd1023, 10'd1023, 1'b1);
      send_edge(32'hAAAA_AAAA, 10'd1023, 10'd1022, 1'b1);

      while (edges_sent < EDGE_ITEMS)
         send_random_graph();
      start <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
design/kufa_pkg.sv
design/kufa_parent_ram.sv
design/kufa_find_ctrl.sv
design/kufa_accum.sv
design/kruskal_union_find_accumulate_top.sv
tb/tree_total_checker.sv
tb/testbench.sv
